/* rtl/asm_lex_pkg.sv */
package asm_lex_pkg;

  localparam int LINE_BITS_DEFAULT   = 16;
  localparam int COLUMN_BITS_DEFAULT = 12;
  localparam int LINE_OUT_BITS       = 16;
  localparam int COLUMN_OUT_BITS     = 12;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  typedef enum logic [1:0] {
    KIND_WORD_CHAR = 2'd0,
    KIND_WORD_END  = 2'd1,
    KIND_SYMBOL    = 2'd2,
    KIND_ILLEGAL   = 2'd3
  } event_kind_t;

  typedef struct packed {
    event_kind_t                  kind;
    logic [7:0]                   ch;
    logic [LINE_OUT_BITS-1:0]     line;
    logic [COLUMN_OUT_BITS-1:0]   column;
    logic                         last;
  } lex_event_t;

  function automatic logic is_symbol(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_DOLLAR) ||
           (c == CH_COMMA) || (c == CH_COLON) || (c == CH_PERIOD);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

/* rtl/assembly_source_lexer.sv */
// Assembly source lexer.
// Input channel: byte_in / end_of_input with byte_valid / byte_stall. One
// source byte per word; end_of_input flushes an open word.
// Output channel: event_kind, char_out, line_out, column_out, last_of_run
// with event_valid / event_stall. Each input word yields zero, one or two
// events; last_of_run marks the final event of an input word.
// An event is written into a four-entry event queue when its input word is
// accepted, and the outputs show the head of that queue.
// Throughput: one input word per cycle while byte_stall is low. Events leave
// one per cycle while event_stall is low; byte_stall rises while more than
// two entries are held. When the receiver stalls, the queue fills and then
// the input is stalled; nothing is dropped.
// After an illegal character the block takes input words but yields no
// events until reset.
// Reset (rst, synchronous, active high) empties the queue and returns the
// position to line 1, column 1 with no word or comment open.
module assembly_source_lexer #(
  parameter int LINE_BITS   = asm_lex_pkg::LINE_BITS_DEFAULT,
  parameter int COLUMN_BITS = asm_lex_pkg::COLUMN_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_in,
  input  logic        end_of_input,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [1:0]  event_kind,
  output logic [7:0]  char_out,
  output logic [15:0] line_out,
  output logic [11:0] column_out,
  output logic        last_of_run
);

  localparam int LOB = asm_lex_pkg::LINE_OUT_BITS;
  localparam int COB = asm_lex_pkg::COLUMN_OUT_BITS;

  logic                   in_comment, in_comment_next;
  logic                   word_open, word_open_next;
  logic                   halted, halted_next;
  logic [LINE_BITS-1:0]   cur_line, cur_line_next;
  logic [COLUMN_BITS-1:0] cur_col, cur_col_next;
  logic [LINE_BITS-1:0]   ws_line, ws_line_next;
  logic [COLUMN_BITS-1:0] ws_col, ws_col_next;

  asm_lex_pkg::lex_event_t fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic       accept, pop;
  logic       emit_end, emit_tok;
  logic [1:0] push_n;
  asm_lex_pkg::lex_event_t ev_end, ev_tok, slot0, slot1;

  logic [LINE_BITS+LOB-1:0]   cur_line_ext, ws_line_ext, st_line_ext;
  logic [COLUMN_BITS+COB-1:0] cur_col_ext, ws_col_ext, st_col_ext;
  logic [LINE_BITS-1:0]       st_line;
  logic [COLUMN_BITS-1:0]     st_col;

  assign byte_stall  = (count > 3'd2);
  assign accept      = byte_valid && !byte_stall;
  assign event_valid = (count != 3'd0);
  assign pop         = event_valid && !event_stall;

  assign cur_line_ext = {{LOB{1'b0}}, cur_line};
  assign cur_col_ext  = {{COB{1'b0}}, cur_col};
  assign ws_line_ext  = {{LOB{1'b0}}, ws_line};
  assign ws_col_ext   = {{COB{1'b0}}, ws_col};
  assign st_line      = word_open ? ws_line : cur_line;
  assign st_col       = word_open ? ws_col : cur_col;
  assign st_line_ext  = {{LOB{1'b0}}, st_line};
  assign st_col_ext   = {{COB{1'b0}}, st_col};

  always_comb begin
    logic bump;
    bump            = 1'b0;
    in_comment_next = in_comment;
    word_open_next  = word_open;
    halted_next     = halted;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    ws_line_next    = ws_line;
    ws_col_next     = ws_col;
    emit_end        = 1'b0;
    emit_tok        = 1'b0;

    ev_end.kind   = asm_lex_pkg::KIND_WORD_END;
    ev_end.ch     = 8'h00;
    ev_end.line   = ws_line_ext[LOB-1:0];
    ev_end.column = ws_col_ext[COB-1:0];
    ev_end.last   = 1'b0;

    ev_tok.kind   = asm_lex_pkg::KIND_SYMBOL;
    ev_tok.ch     = byte_in;
    ev_tok.line   = cur_line_ext[LOB-1:0];
    ev_tok.column = cur_col_ext[COB-1:0];
    ev_tok.last   = 1'b1;

    if (accept && !halted) begin
      if (end_of_input) begin
        emit_end       = word_open;
        word_open_next = 1'b0;
      end else if (byte_in == asm_lex_pkg::CH_NEWLINE) begin
        emit_end        = word_open;
        word_open_next  = 1'b0;
        in_comment_next = 1'b0;
        if (cur_line != {LINE_BITS{1'b1}}) begin
          cur_line_next = cur_line + 1'b1;
        end
        cur_col_next = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
      end else if (in_comment) begin
        bump = 1'b1;
      end else if (byte_in == asm_lex_pkg::CH_HASH) begin
        in_comment_next = 1'b1;
        bump            = 1'b1;
      end else if (byte_in == asm_lex_pkg::CH_SPACE || byte_in == asm_lex_pkg::CH_TAB) begin
        emit_end       = word_open;
        word_open_next = 1'b0;
        bump           = 1'b1;
      end else if (asm_lex_pkg::is_symbol(byte_in)) begin
        emit_end       = word_open;
        word_open_next = 1'b0;
        emit_tok       = 1'b1;
        bump           = 1'b1;
      end else if (asm_lex_pkg::is_word_char(byte_in)) begin
        word_open_next = 1'b1;
        ws_line_next   = st_line;
        ws_col_next    = st_col;
        emit_tok       = 1'b1;
        ev_tok.kind    = asm_lex_pkg::KIND_WORD_CHAR;
        ev_tok.line    = st_line_ext[LOB-1:0];
        ev_tok.column  = st_col_ext[COB-1:0];
        bump           = 1'b1;
      end else begin
        emit_tok    = 1'b1;
        ev_tok.kind = asm_lex_pkg::KIND_ILLEGAL;
        halted_next = 1'b1;
      end
      if (bump && cur_col != {COLUMN_BITS{1'b1}}) begin
        cur_col_next = cur_col + 1'b1;
      end
    end

    ev_end.last = !emit_tok;
    slot0       = emit_end ? ev_end : ev_tok;
    slot1       = ev_tok;
    push_n      = {1'b0, emit_end} + {1'b0, emit_tok};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment <= 1'b0;
      word_open  <= 1'b0;
      halted     <= 1'b0;
      cur_line   <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      cur_col    <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
      ws_line    <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      ws_col     <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
      wr_ptr     <= 2'd0;
      rd_ptr     <= 2'd0;
      count      <= 3'd0;
    end else begin
      in_comment <= in_comment_next;
      word_open  <= word_open_next;
      halted     <= halted_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
      ws_line    <= ws_line_next;
      ws_col     <= ws_col_next;
      wr_ptr     <= wr_ptr + push_n;
      rd_ptr     <= rd_ptr + {1'b0, pop};
      count      <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= slot0;
    end
    if (push_n == 2'd2) begin
      fifo[wr_ptr + 2'd1] <= slot1;
    end
  end

  assign event_kind  = fifo[rd_ptr].kind;
  assign char_out    = fifo[rd_ptr].ch;
  assign line_out    = fifo[rd_ptr].line;
  assign column_out  = fifo[rd_ptr].column;
  assign last_of_run = fifo[rd_ptr].last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("event queue count out of range");

  a_halt_after_illegal: assert property (@(posedge clk) disable iff (rst)
    (accept && !halted && emit_tok && ev_tok.kind == asm_lex_pkg::KIND_ILLEGAL) |=> halted)
    else $error("illegal character did not halt the lexer");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> (push_n == 2'd0))
    else $error("event pushed while halted");

  a_word_end_char: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_kind == asm_lex_pkg::KIND_WORD_END) |-> (char_out == 8'h00))
    else $error("word end carries a character");

endmodule

/* tb/assembly_source_lexer_test.sv */
`timescale 1ns / 1ps

module assembly_source_lexer_test;

  localparam logic [15:0] LINE_SAT = 16'hFFFF;
  localparam logic [11:0] COL_SAT = 12'hFFF;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam logic [7:0] PUNCT [6] = '{asm_lex_pkg::CH_LPAREN, asm_lex_pkg::CH_RPAREN,
                                        asm_lex_pkg::CH_DOLLAR, asm_lex_pkg::CH_COMMA,
                                        asm_lex_pkg::CH_COLON, asm_lex_pkg::CH_PERIOD};

  logic clk;
  logic rst;
  logic byte_valid;
  logic byte_stall;
  logic [7:0] byte_in;
  logic end_of_input;
  logic event_valid;
  logic event_stall;
  logic [1:0] event_kind;
  logic [7:0] char_out;
  logic [15:0] line_out;
  logic [11:0] column_out;
  logic last_of_run;

  // lexer state as the checker sees it
  logic [15:0] pos_line = 16'd1;
  logic [11:0] pos_col = 12'd1;
  logic [15:0] word_line = 16'd1;
  logic [11:0] word_col = 12'd1;
  logic word_open = 1'b0;
  logic in_comment = 1'b0;
  logic halted = 1'b0;
  asm_lex_pkg::lex_event_t events_due[$];

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  int items_sent = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  assembly_source_lexer uut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_in(byte_in),
    .end_of_input(end_of_input),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_kind(event_kind),
    .char_out(char_out),
    .line_out(line_out),
    .column_out(column_out),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_punct(input logic [7:0] c);
    case (c)
      asm_lex_pkg::CH_LPAREN, asm_lex_pkg::CH_RPAREN, asm_lex_pkg::CH_DOLLAR,
      asm_lex_pkg::CH_COMMA, asm_lex_pkg::CH_COLON, asm_lex_pkg::CH_PERIOD: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_legal(input logic [7:0] c);
    return is_alnum(c) || is_punct(c) || c == asm_lex_pkg::CH_SPACE ||
           c == asm_lex_pkg::CH_TAB || c == asm_lex_pkg::CH_NEWLINE ||
           c == asm_lex_pkg::CH_HASH;
  endfunction

  function automatic void predict_lex_events(input logic [7:0] c, input logic eoi);
    asm_lex_pkg::lex_event_t ev;
    asm_lex_pkg::lex_event_t ev_end;
    logic closes;
    logic emits;
    logic bumps;
    closes = 1'b0;
    emits = 1'b0;
    bumps = 1'b0;
    ev = '0;
    ev_end = '0;
    if (halted) return;
    if (eoi) begin
      closes = 1'b1;
    end else if (c == asm_lex_pkg::CH_NEWLINE) begin
      closes = 1'b1;
      in_comment = 1'b0;
      if (pos_line != LINE_SAT) pos_line++;
      pos_col = 12'd1;
    end else if (in_comment) begin
      bumps = 1'b1;
    end else if (c == asm_lex_pkg::CH_HASH) begin
      in_comment = 1'b1;
      bumps = 1'b1;
    end else if (c == asm_lex_pkg::CH_SPACE || c == asm_lex_pkg::CH_TAB) begin
      closes = 1'b1;
      bumps = 1'b1;
    end else if (is_punct(c)) begin
      closes = 1'b1;
      emits = 1'b1;
      bumps = 1'b1;
      ev.kind = asm_lex_pkg::KIND_SYMBOL;
      ev.ch = c;
      ev.line = pos_line;
      ev.column = pos_col;
    end else if (is_alnum(c)) begin
      if (!word_open) begin
        word_open = 1'b1;
        word_line = pos_line;
        word_col = pos_col;
      end
      emits = 1'b1;
      bumps = 1'b1;
      ev.kind = asm_lex_pkg::KIND_WORD_CHAR;
      ev.ch = c;
      ev.line = word_line;
      ev.column = word_col;
    end else begin
      emits = 1'b1;
      ev.kind = asm_lex_pkg::KIND_ILLEGAL;
      ev.ch = c;
      ev.line = pos_line;
      ev.column = pos_col;
      halted = 1'b1;
    end
    if (bumps && pos_col != COL_SAT) pos_col++;
    if (closes && word_open) begin
      ev_end.kind = asm_lex_pkg::KIND_WORD_END;
      ev_end.ch = 8'h00;
      ev_end.line = word_line;
      ev_end.column = word_col;
      ev_end.last = !emits;
      events_due = {events_due, ev_end};
      word_open = 1'b0;
    end
    if (emits) begin
      ev.last = 1'b1;
      events_due = {events_due, ev};
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // outputs first, then the word taken in at this edge; watchdog on both channels
  always @(posedge clk) begin
    asm_lex_pkg::lex_event_t want;
    if (!rst) begin
      if (event_valid && !event_stall) begin
        if (events_due.size() == 0) begin
          $display("%0t: unexpected event, expected none, got kind %0d char %0h line %0d col %0d",
                   $time, event_kind, char_out, line_out, column_out);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          check_field("event_kind", want.kind, event_kind);
          check_field("char_out", want.ch, char_out);
          check_field("line_out", want.line, line_out);
          check_field("column_out", want.column, column_out);
          check_field("last_of_run", want.last, last_of_run);
        end
      end
      if (byte_valid && !byte_stall) predict_lex_events(byte_in, end_of_input);
    end
    if ((byte_valid && !byte_stall) || (event_valid && !event_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("** assembly_source_lexer: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    else if (r < 96) return $urandom_range(12, 4);
    else return $urandom_range(60, 20);
  endfunction

  initial begin : receiver
    event_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        event_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        event_stall <= 1'b1;
        repeat (pick_gap() - 1) @(negedge clk);
      end else begin
        event_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_in <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (byte_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 10) return 8'(8'h30 + r);
    else if (r < 36) return 8'(8'h41 + r - 10);
    else return 8'(8'h61 + r - 36);
  endfunction

  task automatic send_word();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(14, 7) : $urandom_range(6, 1);
    repeat (n) send_byte(rand_alnum(), 1'b0);
  endtask

  task automatic send_blanks();
    repeat ($urandom_range(2))
      send_byte($urandom_range(1) ? asm_lex_pkg::CH_SPACE : asm_lex_pkg::CH_TAB, 1'b0);
  endtask

  // anything but newline may sit inside a comment
  task automatic send_comment();
    logic [7:0] b;
    send_byte(asm_lex_pkg::CH_HASH, 1'b0);
    repeat ($urandom_range(15)) begin
      do b = 8'($urandom_range(255)); while (b == asm_lex_pkg::CH_NEWLINE);
      send_byte(b, 1'b0);
    end
  endtask

  task automatic send_source_line();
    int n_ops;
    if ($urandom_range(4) == 0) begin
      send_word();
      send_byte(asm_lex_pkg::CH_COLON, 1'b0);
    end
    send_blanks();
    send_word();
    n_ops = $urandom_range(3);
    for (int i = 0; i < n_ops; i++) begin
      if (i != 0) send_byte(asm_lex_pkg::CH_COMMA, 1'b0);
      send_blanks();
      case ($urandom_range(4))
        0: begin
          send_byte(asm_lex_pkg::CH_DOLLAR, 1'b0);
          send_word();
        end
        1: send_word();
        2: begin
          send_byte(asm_lex_pkg::CH_LPAREN, 1'b0);
          send_word();
          send_byte(asm_lex_pkg::CH_RPAREN, 1'b0);
        end
        3: begin
          send_word();
          send_byte(asm_lex_pkg::CH_LPAREN, 1'b0);
          send_word();
          send_byte(asm_lex_pkg::CH_RPAREN, 1'b0);
        end
        default: begin
          send_byte(asm_lex_pkg::CH_PERIOD, 1'b0);
          send_word();
        end
      endcase
    end
    if ($urandom_range(3) == 0) send_comment();
    if ($urandom_range(19) == 0) send_byte(8'($urandom_range(255)), 1'b1);
    send_byte(asm_lex_pkg::CH_NEWLINE, 1'b0);
  endtask

  // legal bytes in any order, plus end-of-input words
  task automatic send_noise(input int n);
    repeat (n) begin
      case ($urandom_range(7))
        0, 1: send_byte(rand_alnum(), 1'b0);
        2, 3: send_byte(PUNCT[$urandom_range(5)], 1'b0);
        4: send_byte($urandom_range(1) ? asm_lex_pkg::CH_SPACE : asm_lex_pkg::CH_TAB, 1'b0);
        5: send_byte(asm_lex_pkg::CH_NEWLINE, 1'b0);
        6: send_byte(asm_lex_pkg::CH_HASH, 1'b0);
        default: send_byte(8'($urandom_range(255)), 1'b1);
      endcase
    end
  endtask

  task automatic pick_idling();
    case ($urandom_range(3))
      0: idle_pct = 0;
      1: idle_pct = 10;
      2: idle_pct = 30;
      default: idle_pct = 60;
    endcase
    case ($urandom_range(3))
      0: stall_pct = 0;
      1: stall_pct = 10;
      2: stall_pct = 30;
      default: stall_pct = 60;
    endcase
  endtask

  task automatic test_directed_cases();
    idle_pct = 0;
    stall_pct = 0;
    send_text("0z9A Za(b)\t$x,:.#(");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\nk#r\nw");
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_source();
    int target;
    int lines;
    target = items_sent + 1550;
    lines = 0;
    while (items_sent < target) begin
      if (lines % 12 == 0) pick_idling();
      if ($urandom_range(9) < 8) send_source_line();
      else send_noise($urandom_range(12, 1));
      lines++;
    end
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b1;
    repeat (15) send_text("ab(c) ");
    send_byte(asm_lex_pkg::CH_NEWLINE, 1'b0);
  endtask

  task automatic test_illegal_halt();
    logic [7:0] bad;
    idle_pct = 20;
    stall_pct = 20;
    send_text("\nop");
    do bad = 8'($urandom_range(255)); while (is_legal(bad));
    send_byte(bad, 1'b0);
    repeat (40) send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  initial begin
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_in = 8'h00;
    end_of_input = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_source();
    test_backpressure();
    test_illegal_halt();
    byte_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("** assembly_source_lexer: PASSED **");
    else $display("** assembly_source_lexer: FAILED **");
    $finish;
  end

endmodule

/* assembly_source_lexer.f */
rtl/asm_lex_pkg.sv
rtl/assembly_source_lexer.sv
tb/assembly_source_lexer_test.sv
